### hdl/display_command_queue_macros.svh
// Assertion macros for the display command queue.
// Expects aclk and aresetn in the scope of each use.
`ifndef DISPLAY_COMMAND_QUEUE_MACROS_SVH
`define DISPLAY_COMMAND_QUEUE_MACROS_SVH

// Same-cycle implication, checked out of reset only.
`define DCQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("display command queue: same-cycle check failed");

// Next-cycle implication, checked out of reset only.
`define DCQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("display command queue: next-cycle check failed");

`endif

### hdl/dcq_pkg.sv
// Shared types, codes and the entry decoder for the display command queue.
// No dependencies.
package dcq_pkg;

    // Request kinds on the input channel
    typedef enum logic [1:0] {
        OP_PUT    = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_CURSOR = 2'd2,
        OP_SEND   = 2'd3
    } op_t;

    // Display actions on the result channel
    typedef enum logic [1:0] {
        ACT_CHAR   = 2'd0,
        ACT_CLEAR  = 2'd1,
        ACT_CURSOR = 2'd2
    } action_t;

    localparam logic [7:0] CODE_CLEAR  = 8'h80;
    localparam logic [1:0] CURSOR_TAG  = 2'b11;

    // Per-cycle control broadcast to every cell of the chain
    typedef struct packed {
        logic       clear;
        logic       pop;
        logic       push;
        logic [7:0] push_data;
    } cell_ctrl_t;

    // One decoded queue entry
    typedef struct packed {
        logic       valid;
        action_t    action;
        logic [6:0] char_value;
        logic [3:0] cursor_col;
        logic [1:0] cursor_row;
    } decoded_t;

    // Characters below 0x80, clear at 0x80, cursor moves at 0xC0 and up;
    // the rest of the 0x80 range decodes to nothing.
    function automatic decoded_t decode_entry(input logic [7:0] code);
        decoded_t d;
        d = '0;
        d.action = ACT_CHAR;
        if (!code[7]) begin
            d.valid      = 1'b1;
            d.char_value = code[6:0];
        end else if (code == CODE_CLEAR) begin
            d.valid  = 1'b1;
            d.action = ACT_CLEAR;
        end else if (code[7:6] == CURSOR_TAG) begin
            d.valid      = 1'b1;
            d.action     = ACT_CURSOR;
            d.cursor_col = code[5:2];
            d.cursor_row = code[1:0];
        end
        return d;
    endfunction

endpackage

### hdl/display_command_queue.sv
// Display command queue: a chain of byte cells, head at cell 0, with decode at the head.
// Registered result: it appears on m_ in the cycle after the request that pops its entry.
// One request per cycle unless m_ stalls; each request moves the whole chain at most one slot.
// Reset: aresetn (synchronous, active low) empties the queue and drops a pending result.
// Depends on dcq_pkg, dcq_cell and display_command_queue_macros.svh.
`include "display_command_queue_macros.svh"
module display_command_queue #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // byte_value[7:0], column[11:8], row_index[13:12], zero pad
    input  logic [1:0]  s_tuser,   // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // char_value[6:0], cursor_col[10:7], cursor_row[12:11],
                                   // more_pending[13], zero pad
    output logic [1:0]  m_tuser    // action[1:0]
);
    import dcq_pkg::*;

    logic             in_fire;
    op_t              op;
    logic [7:0]       byte_value;
    logic [3:0]       column;
    logic [1:0]       row_index;
    cell_ctrl_t       ctrl;
    logic [QUEUE_DEPTH-1:0] valid_vec;
    logic [7:0]       data_arr [QUEUE_DEPTH];
    logic             q_empty, q_full;
    decoded_t         head_dec;

    logic             m_valid_reg, m_valid_next;
    decoded_t         res_reg;
    logic             more_reg;

    assign op         = op_t'(s_tuser);
    assign byte_value = s_tdata[7:0];
    assign column     = s_tdata[11:8];
    assign row_index  = s_tdata[13:12];

    // Output register frees up when empty or being taken this cycle
    assign s_tready = !m_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    assign q_empty  = !valid_vec[0];
    assign q_full   = valid_vec[QUEUE_DEPTH-1];
    assign head_dec = decode_entry(data_arr[0]);

    // Request decoder: drives the chain's control
    always_comb begin
        ctrl = '0;
        if (in_fire) begin
            unique case (op)
                OP_PUT: begin
                    ctrl.push      = 1'b1;
                    ctrl.pop       = q_full;
                    ctrl.push_data = byte_value;
                end
                OP_CLEAR: begin
                    ctrl.clear = 1'b1;
                end
                OP_CURSOR: begin
                    ctrl.push      = 1'b1;
                    ctrl.pop       = q_full;
                    ctrl.push_data = {CURSOR_TAG, column, row_index};
                end
                OP_SEND: begin
                    ctrl.pop = !q_empty;
                end
                default: begin
                    ctrl = '0;
                end
            endcase
        end
    end

    // Chain of cells, each fed by its younger neighbor
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        logic       prev_v;
        logic       next_v;
        logic [7:0] next_d;
        if (i == 0) begin : g_head
            assign prev_v = 1'b1;
        end else begin : g_body
            assign prev_v = valid_vec[i-1];
        end
        if (i == QUEUE_DEPTH - 1) begin : g_tail
            assign next_v = 1'b0;
            assign next_d = '0;
        end else begin : g_link
            assign next_v = valid_vec[i+1];
            assign next_d = data_arr[i+1];
        end
        dcq_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .first_cell (i == 0),
            .prev_valid (prev_v),
            .next_valid (next_v),
            .next_data  (next_d),
            .valid      (valid_vec[i]),
            .data       (data_arr[i])
        );
    end

    // Result register: loaded when a pop decodes to an action
    always_comb begin
        m_valid_next = m_valid_reg;
        if (in_fire) begin
            m_valid_next = ctrl.pop && head_dec.valid;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && ctrl.pop && head_dec.valid) begin
            res_reg  <= head_dec;
            // cell 1 becomes the head after the pop
            more_reg <= valid_vec[1];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = res_reg.action;
    assign m_tdata  = {2'b00, more_reg, res_reg.cursor_row, res_reg.cursor_col,
                       res_reg.char_value};

    // Occupied cells always form an unbroken run from the head
    `DCQ_ASSERT_NOW(a_valid_contiguous, 1'b1, ((valid_vec + QUEUE_DEPTH'(1)) & valid_vec) == '0)
    // A clear leaves exactly the clear code at the head
    `DCQ_ASSERT_NEXT(a_clear_leaves_one, in_fire && op == OP_CLEAR,
        valid_vec == QUEUE_DEPTH'(1) && data_arr[0] == CODE_CLEAR)
    // A send on an empty queue gives nothing
    `DCQ_ASSERT_NEXT(a_empty_send_silent, in_fire && op == OP_SEND && q_empty, !m_tvalid)
    // A new result only follows an accepted request
    `DCQ_ASSERT_NOW(a_result_has_request, $rose(m_tvalid), $past(in_fire))

endmodule

### hdl/dcq_cell.sv
// One slot of the shifting command queue: a valid bit and a command byte.
// Depends on dcq_pkg; neighbors are wired up by display_command_queue.
module dcq_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  dcq_pkg::cell_ctrl_t ctrl,
    input  logic               first_cell,  // this slot is the queue head
    input  logic               prev_valid,  // older neighbor holds an entry
    input  logic               next_valid,  // younger neighbor holds an entry
    input  logic [7:0]         next_data,
    output logic               valid,
    output logic [7:0]         data
);
    import dcq_pkg::*;

    logic       valid_reg, valid_next;
    logic [7:0] data_reg, data_next;
    logic       load_here;

    // Next slot contents: clear, shift toward the head, or append at the tail
    always_comb begin
        load_here  = 1'b0;
        valid_next = valid_reg;
        data_next  = data_reg;
        if (ctrl.clear) begin
            valid_next = first_cell;
            data_next  = CODE_CLEAR;
        end else if (ctrl.pop) begin
            // after the shift the old tail slot is the first free one
            load_here  = ctrl.push && valid_reg && !next_valid;
            valid_next = next_valid || load_here;
            data_next  = load_here ? ctrl.push_data : next_data;
        end else begin
            load_here  = ctrl.push && !valid_reg && prev_valid;
            valid_next = valid_reg || load_here;
            data_next  = load_here ? ctrl.push_data : data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

### tb/sv/tb_display_command_queue.sv
// Self-checking testbench for display_command_queue: it sends requests and checks every decoded
// display action against an in-bench model of the 32-entry queue that overwrites its oldest entry.
// Depends on dcq_pkg and the display_command_queue RTL.
`timescale 1ns / 100ps

module tb_display_command_queue;
    import dcq_pkg::*;

    localparam int DEPTH            = 32;
    localparam int PTR_W            = $clog2(DEPTH);
    localparam int RANDOM_ITEMS     = 300;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int CYCLE_LIMIT      = 200000;

    // Expected decoded action, one per popped entry that decodes to something
    typedef struct packed {
        action_t    action;
        logic [6:0] char_value;
        logic [3:0] cursor_col;
        logic [1:0] cursor_row;
        logic       more_pending;
    } display_action_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // byte_value[7:0], column[11:8], row_index[13:12], zero pad
    logic [1:0]  s_tuser;   // operation[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // char_value[6:0], cursor_col[10:7], cursor_row[12:11],
                            // more_pending[13], zero pad
    logic [1:0]  m_tuser;   // action[1:0]

    // Queue model state
    logic [7:0]       cmd_store [DEPTH];
    logic [PTR_W-1:0] rd_ptr     = '0;
    logic [PTR_W-1:0] wr_ptr     = '0;
    bit               queue_full = 1'b0;

    display_action_t pending_actions[$];
    int              error_count   = 0;
    int              cycle_count   = 0;
    int              burst_left    = 0;
    int              ready_mode    = 0;
    int              mode_left     = 0;
    bit              long_hold_req = 1'b0;

    display_command_queue #(.QUEUE_DEPTH(DEPTH)) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL display_command_queue");
            $finish;
        end
    end

    //------------------------------------------------------------------
    // Queue model
    //------------------------------------------------------------------

    // Pop the head entry; codes 0x81..0xBF are dropped without an action
    function automatic void pop_oldest();
        logic [7:0]      code;
        display_action_t act;
        bit              gives;
        code       = cmd_store[rd_ptr];
        rd_ptr     = rd_ptr + PTR_W'(1);
        queue_full = 1'b0;
        act        = '0;
        gives      = 1'b1;
        if (!code[7]) begin
            act.action     = ACT_CHAR;
            act.char_value = code[6:0];
        end else if (code == CODE_CLEAR) begin
            act.action = ACT_CLEAR;
        end else if (code[7:6] == CURSOR_TAG) begin
            act.action     = ACT_CURSOR;
            act.cursor_col = code[5:2];
            act.cursor_row = code[1:0];
        end else begin
            gives = 1'b0;
        end
        act.more_pending = (rd_ptr != wr_ptr);
        if (gives)
            pending_actions.push_back(act);
    endfunction

    // A store into a full queue pushes the oldest entry out first
    function automatic void store_code(input logic [7:0] code);
        if (queue_full)
            pop_oldest();
        cmd_store[wr_ptr] = code;
        wr_ptr            = wr_ptr + PTR_W'(1);
        queue_full        = (rd_ptr == wr_ptr);
    endfunction

    function automatic void predict_request(input op_t op, input logic [7:0] raw,
                                            input logic [3:0] col, input logic [1:0] row);
        case (op)
            OP_PUT: begin
                store_code(raw);
            end
            OP_CLEAR: begin
                rd_ptr     = '0;
                wr_ptr     = '0;
                queue_full = 1'b0;
                store_code(CODE_CLEAR);
            end
            OP_CURSOR: begin
                store_code({CURSOR_TAG, col, row});
            end
            default: begin
                // send on an empty queue does nothing
                if (queue_full || rd_ptr != wr_ptr)
                    pop_oldest();
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endfunction

    //------------------------------------------------------------------
    // Result check, then prediction of the request taken at this edge
    //------------------------------------------------------------------
    always @(posedge aclk) begin
        display_action_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_actions.size() == 0) begin
                    $error("result with no expected action: tuser %0h tdata %0h",
                           m_tuser, m_tdata);
                    error_count++;
                end else begin
                    want = pending_actions.pop_front();
                    check_field("action", want.action, m_tuser);
                    check_field("char_value", want.char_value, m_tdata[6:0]);
                    check_field("cursor_col", want.cursor_col, m_tdata[10:7]);
                    check_field("cursor_row", want.cursor_row, m_tdata[12:11]);
                    check_field("more_pending", want.more_pending, m_tdata[13]);
                    check_field("m_tdata pad", 0, m_tdata[15:14]);
                end
            end
            if (s_tvalid && s_tready)
                predict_request(op_t'(s_tuser), s_tdata[7:0], s_tdata[11:8], s_tdata[13:12]);
        end
    end

    //------------------------------------------------------------------
    // Receiver: changing ready patterns, plus a long hold on request
    //------------------------------------------------------------------
    always begin
        @(negedge aclk);
        if (long_hold_req) begin
            m_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge aclk);
            long_hold_req = 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(8, 64);
            end
            mode_left--;
            case (ready_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ((cycle_count % 5) < 3);
            endcase
        end
    end

    //------------------------------------------------------------------
    // Sender
    //------------------------------------------------------------------

    // Drive one request and hold it until taken; bursts with random gaps
    task automatic send_request(input op_t op, input logic [7:0] raw,
                                input logic [3:0] col, input logic [1:0] row);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = $urandom_range(0, 6);
            if (gap != 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                s_tdata  <= 16'($urandom_range(0, 16'h3FFF));
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, row, col, raw};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Random content; a fifth of the raw bytes are drawn from the 0x80..0xBF codes
    task automatic send_random_request(input op_t op);
        logic [7:0] raw;
        if ($urandom_range(0, 4) == 0)
            raw = 8'h80 + 8'($urandom_range(0, 63));
        else
            raw = 8'($urandom_range(0, 255));
        send_request(op, raw, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)));
    endtask

    // Drop valid and let every expected action come out
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_actions.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------

    // Every decode class and field extreme, send on empty at both ends
    task automatic test_decode_extremes();
        send_request(OP_SEND, 8'hFF, 4'hF, 2'd3);
        send_request(OP_PUT, 8'h00, 4'hF, 2'd3);
        send_request(OP_PUT, 8'h7F, 4'h0, 2'd0);
        send_request(OP_PUT, 8'h80, 4'h5, 2'd2);
        send_request(OP_PUT, 8'h81, 4'hA, 2'd1);
        send_request(OP_PUT, 8'hBF, 4'h0, 2'd0);
        send_request(OP_PUT, 8'hC0, 4'h0, 2'd0);
        send_request(OP_PUT, 8'hFF, 4'h0, 2'd0);
        send_request(OP_CURSOR, 8'hFF, 4'hF, 2'd3);
        send_request(OP_CURSOR, 8'h00, 4'h0, 2'd0);
        send_request(OP_CURSOR, 8'h55, 4'hA, 2'd1);
        send_request(OP_PUT, 8'h2A, 4'h5, 2'd2);
        repeat (12) send_request(OP_SEND, 8'h00, 4'h0, 2'd0);
        wait_idle();
    endtask

    // Fill to full, overwrite the oldest a few times, then clear a full queue
    task automatic test_clear_and_overwrite();
        send_request(OP_CLEAR, 8'h00, 4'h0, 2'd0);
        repeat (DEPTH + 3) send_random_request(OP_PUT);
        send_request(OP_CLEAR, 8'hC3, 4'h9, 2'd2);
        repeat (3) send_request(OP_SEND, 8'h00, 4'h0, 2'd0);
        wait_idle();
    endtask

    // Receiver holds off while a full queue keeps producing actions
    task automatic test_receiver_backpressure();
        send_request(OP_CLEAR, 8'h00, 4'h0, 2'd0);
        repeat (DEPTH - 1) send_random_request(OP_CURSOR);
        long_hold_req = 1'b1;
        repeat (12) send_random_request(OP_PUT);
        repeat (8) send_random_request(OP_SEND);
        wait_idle();
    endtask

    // Segments with a drifting put/send mix so the queue fills and drains
    task automatic test_random_traffic();
        int  sent;
        int  seg_left;
        int  put_weight;
        int  pick;
        op_t op;
        sent     = 0;
        seg_left = 0;
        put_weight = 50;
        while (sent < RANDOM_ITEMS) begin
            if (seg_left == 0) begin
                seg_left   = $urandom_range(16, 64);
                put_weight = $urandom_range(20, 75);
            end
            pick = $urandom_range(0, 99);
            if (pick < 4)
                op = OP_CLEAR;
            else if (pick < 4 + put_weight)
                op = ($urandom_range(0, 2) == 0) ? OP_CURSOR : OP_PUT;
            else
                op = OP_SEND;
            send_random_request(op);
            sent++;
            seg_left--;
        end
        wait_idle();
    endtask

    //------------------------------------------------------------------
    // Main sequence
    //------------------------------------------------------------------
    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_PUT;
        m_tready = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_decode_extremes();
        test_clear_and_overwrite();
        test_receiver_backpressure();
        test_random_traffic();

        repeat (8) @(posedge aclk);
        if (error_count == 0) begin
            $display("PASS display_command_queue");
        end else begin
            $display("FAIL display_command_queue");
        end
        $finish;
    end

endmodule

### display_command_queue.f
+incdir+hdl
hdl/dcq_pkg.sv
hdl/dcq_cell.sv
hdl/display_command_queue.sv
tb/sv/tb_display_command_queue.sv
